// ----- hw/rtl/tpsc_pkg.sv -----
// Shared types, widths and codes of the three-wheel speed controller.
package tpsc_pkg;

	localparam int NUM_WHEELS = 3;
	localparam int SPEED_BITS = 16;
	localparam int GAIN_W     = 16;
	localparam int PCT_W      = 7;
	localparam int DRIVE_W    = PCT_W + 1;
	localparam int INTEG_W    = 16;
	localparam int FRAC_W     = 8;
	localparam int ERR_W      = SPEED_BITS + 1;
	localparam int DIFF_W     = ERR_W + 1;
	localparam int PI_W       = GAIN_W + 1 + ERR_W;
	localparam int PD_W       = GAIN_W + 1 + DIFF_W;
	localparam int SUM_W      = PD_W + 1;
	localparam int LIM_W      = PCT_W + FRAC_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// commands
	localparam logic [2:0] CMD_TICK      = 3'd0;
	localparam logic [2:0] CMD_SET_ONE   = 3'd1;
	localparam logic [2:0] CMD_SET_ALL   = 3'd2;
	localparam logic [2:0] CMD_STOP      = 3'd3;
	localparam logic [2:0] CMD_RESET_ONE = 3'd4;
	localparam logic [2:0] CMD_RESET_ALL = 3'd5;
	localparam logic [2:0] CMD_ENABLE    = 3'd6;
	localparam logic [2:0] CMD_DISABLE   = 3'd7;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEG  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_REF_MIN     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_REF_MAX     = 3'd6;

	typedef struct packed {
		logic [2:0]                   cmd;
		logic [1:0]                   wheel;
		logic signed [SPEED_BITS-1:0] ref_speed;
		logic                         unit_is_rps;
		logic signed [SPEED_BITS-1:0] meas_a;
		logic signed [SPEED_BITS-1:0] meas_b;
		logic signed [SPEED_BITS-1:0] meas_c;
	} tpsc_req_t;

	typedef struct packed {
		logic signed [DRIVE_W-1:0] drive_a;
		logic signed [DRIVE_W-1:0] drive_b;
		logic signed [DRIVE_W-1:0] drive_c;
		logic [NUM_WHEELS-1:0]     apply_mask;
		logic                      loop_on;
	} tpsc_rsp_t;

	// gain set shared by all wheels
	typedef struct packed {
		logic [GAIN_W-1:0] gain_prop;
		logic [GAIN_W-1:0] gain_integ;
		logic [GAIN_W-1:0] gain_deriv;
		logic [PCT_W-1:0]  integ_limit;
		logic [PCT_W-1:0]  dead_zone;
	} tpsc_gains_t;

	// per-wheel update strobes, at most one set
	typedef struct packed {
		logic tick;
		logic set_ref;
		logic zero_ref;
		logic clear;
	} tpsc_wctl_t;

endpackage

// ----- hw/rtl/three_wheel_pi_speed_controller_core.sv -----
// Top level of the three-wheel PI speed controller: command decode, config, beat staging.
//
//  channel | direction | handshake              | payload
//  req     | in        | req_valid / req_stall  | req_data  (tpsc_req_t)
//  rsp     | out       | rsp_valid / rsp_stall  | rsp_data  (tpsc_rsp_t)
//  cfg     | in        | cfg_we                 | cfg_index, cfg_wdata
//
// Request beat to response beat: input register, then one pass through the per-wheel
// multiply-add paths into wheel state and the response register. One beat per cycle
// when not stalled; all wheel state is read and written in the same stage.
// Reset clears the wheels, disables the loop and loads the default gains; no clearing pass.
// A stalled response holds the input register; req_stall rises only when both are full.
module three_wheel_pi_speed_controller_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 req_valid,
	output logic                                 req_stall,
	input  tpsc_pkg::tpsc_req_t                  req_data,
	output logic                                 rsp_valid,
	input  logic                                 rsp_stall,
	output tpsc_pkg::tpsc_rsp_t                  rsp_data,
	input  logic                                 cfg_we,
	input  logic [tpsc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tpsc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
	import tpsc_pkg::*;

	tpsc_gains_t                  gains_q;
	logic signed [SPEED_BITS-1:0] ref_min_q;
	logic signed [SPEED_BITS-1:0] ref_max_q;
	logic                         enable_q;

	tpsc_req_t req_s1;
	logic      vld_s1;
	tpsc_rsp_t rsp_q;
	logic      rsp_valid_q;

	logic                         out_free;
	logic                         go;
	logic                         wheel_ok;
	logic signed [SPEED_BITS-1:0] ref_lo;
	logic signed [SPEED_BITS-1:0] ref_val;
	logic                         enable_nxt;
	logic [NUM_WHEELS-1:0]        mask;
	tpsc_wctl_t                   wctl [NUM_WHEELS];
	logic signed [SPEED_BITS-1:0] meas [NUM_WHEELS];
	logic signed [DRIVE_W-1:0]    drive [NUM_WHEELS];

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign go        = vld_s1 && out_free;
	assign req_stall = vld_s1 && !out_free;
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q.gain_prop   <= 16'd12800;
			gains_q.gain_integ  <= 16'd768;
			gains_q.gain_deriv  <= '0;
			gains_q.integ_limit <= 7'd100;
			gains_q.dead_zone   <= 7'd5;
			ref_min_q           <= {1'b1, {(SPEED_BITS-1){1'b0}}};
			ref_max_q           <= {1'b0, {(SPEED_BITS-1){1'b1}}};
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GAIN_PROP:   gains_q.gain_prop   <= cfg_wdata[GAIN_W-1:0];
				REG_GAIN_INTEG:  gains_q.gain_integ  <= cfg_wdata[GAIN_W-1:0];
				REG_GAIN_DERIV:  gains_q.gain_deriv  <= cfg_wdata[GAIN_W-1:0];
				REG_INTEG_LIMIT: gains_q.integ_limit <= cfg_wdata[PCT_W-1:0];
				REG_DEAD_ZONE:   gains_q.dead_zone   <= cfg_wdata[PCT_W-1:0];
				REG_REF_MIN:     ref_min_q           <= cfg_wdata[SPEED_BITS-1:0];
				REG_REF_MAX:     ref_max_q           <= cfg_wdata[SPEED_BITS-1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (req_valid && !req_stall) begin
			vld_s1 <= 1'b1;
		end else if (out_free) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req_data;
		end
	end

	// command decode
	always_comb begin
		wheel_ok = 32'(req_s1.wheel) < NUM_WHEELS;
		ref_lo   = (req_s1.ref_speed < ref_min_q) ? ref_min_q : req_s1.ref_speed;
		if (!req_s1.unit_is_rps) begin
			ref_val = '0;
		end else if (ref_lo > ref_max_q) begin
			ref_val = ref_max_q;
		end else begin
			ref_val = ref_lo;
		end

		enable_nxt = enable_q;
		mask       = '0;
		for (int w = 0; w < NUM_WHEELS; w++) begin
			wctl[w] = '0;
		end
		case (req_s1.cmd)
			CMD_TICK: begin
				if (enable_q) begin
					mask = '1;
					for (int w = 0; w < NUM_WHEELS; w++) begin
						wctl[w].tick = go;
					end
				end
			end
			CMD_SET_ONE: begin
				for (int w = 0; w < NUM_WHEELS; w++) begin
					wctl[w].set_ref = go && wheel_ok && (32'(req_s1.wheel) == w);
				end
			end
			CMD_SET_ALL: begin
				for (int w = 0; w < NUM_WHEELS; w++) begin
					wctl[w].set_ref = go;
				end
			end
			CMD_STOP: begin
				for (int w = 0; w < NUM_WHEELS; w++) begin
					wctl[w].zero_ref = go;
				end
			end
			CMD_RESET_ONE: begin
				if (wheel_ok) begin
					enable_nxt = 1'b0;
					mask       = NUM_WHEELS'(1) << req_s1.wheel;
					for (int w = 0; w < NUM_WHEELS; w++) begin
						wctl[w].clear = go && (32'(req_s1.wheel) == w);
					end
				end
			end
			CMD_RESET_ALL: begin
				enable_nxt = 1'b0;
				mask       = '1;
				for (int w = 0; w < NUM_WHEELS; w++) begin
					wctl[w].clear = go;
				end
			end
			CMD_ENABLE:  enable_nxt = 1'b1;
			CMD_DISABLE: enable_nxt = 1'b0;
			default: ;
		endcase
	end

	assign meas[0] = req_s1.meas_a;
	assign meas[1] = req_s1.meas_b;
	assign meas[2] = req_s1.meas_c;

	for (genvar g = 0; g < NUM_WHEELS; g++) begin : g_wheel
		tpsc_wheel u_wheel (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (wctl[g]),
			.gains     (gains_q),
			.ref_val   (ref_val),
			.meas      (meas[g]),
			.drive_nxt (drive[g])
		);
	end

	// loop enable and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (go) begin
				enable_q <= enable_nxt;
			end
			if (out_free) begin
				rsp_valid_q <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rsp_q.drive_a    <= drive[0];
			rsp_q.drive_b    <= drive[1];
			rsp_q.drive_c    <= drive[2];
			rsp_q.apply_mask <= mask;
			rsp_q.loop_on    <= enable_nxt;
		end
	end

	// a held beat in the input register is never dropped
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !out_free |=> vld_s1)
		else $error("input beat lost while output stalled");

	// reset all leaves every drive at zero and the loop off
	assert property (@(posedge clk) disable iff (!arst_n)
		go && req_s1.cmd == CMD_RESET_ALL |=>
			rsp_q.drive_a == '0 && rsp_q.drive_b == '0 && rsp_q.drive_c == '0 &&
			!rsp_q.loop_on && !enable_q)
		else $error("reset all did not clear the wheels");

	// with the loop on, drives are applied to all wheels or none
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.loop_on |-> rsp_q.apply_mask == '0 || rsp_q.apply_mask == '1)
		else $error("partial apply mask with loop enabled");

	// saturation never yields the most negative code
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> rsp_q.drive_a != $signed({1'b1, {PCT_W{1'b0}}}) &&
			rsp_q.drive_b != $signed({1'b1, {PCT_W{1'b0}}}) &&
			rsp_q.drive_c != $signed({1'b1, {PCT_W{1'b0}}}))
		else $error("drive outside plus or minus 127");

	// response register follows the loop flag
	assert property (@(posedge clk) disable iff (!arst_n)
		go |=> rsp_q.loop_on == enable_q)
		else $error("loop_on disagrees with enable state");

endmodule

// ----- hw/rtl/tpsc_wheel.sv -----
// One wheel's controller state and its PID update datapath.
module tpsc_wheel (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  tpsc_pkg::tpsc_wctl_t                   ctl,
	input  tpsc_pkg::tpsc_gains_t                  gains,
	input  logic signed [tpsc_pkg::SPEED_BITS-1:0] ref_val,
	input  logic signed [tpsc_pkg::SPEED_BITS-1:0] meas,
	output logic signed [tpsc_pkg::DRIVE_W-1:0]    drive_nxt
);
	import tpsc_pkg::*;

	logic signed [SPEED_BITS-1:0] ref_q;
	logic signed [INTEG_W-1:0]    integ_q;
	logic signed [ERR_W-1:0]      last_err_q;
	logic signed [DRIVE_W-1:0]    drive_q;

	logic signed [ERR_W-1:0]   err;
	logic signed [DIFF_W-1:0]  diff;
	logic signed [PI_W-1:0]    prod_i;
	logic signed [PI_W-1:0]    acc;
	logic signed [PI_W-1:0]    lim;
	logic signed [PI_W-1:0]    acc_c;
	logic signed [INTEG_W-1:0] integ_nxt;
	logic signed [INTEG_W+FRAC_W-1:0] integ_sh;
	logic signed [PI_W-1:0]    prod_p;
	logic signed [PD_W-1:0]    prod_d;
	logic signed [SUM_W-1:0]   sum;
	logic [SUM_W-1:0]          mag;
	logic [PCT_W-1:0]          pct;
	logic signed [DRIVE_W-1:0] drive_calc;

	always_comb begin
		err    = ERR_W'(ref_q) - ERR_W'(meas);
		diff   = DIFF_W'(err) - DIFF_W'(last_err_q);
		prod_i = PI_W'($signed({1'b0, gains.gain_integ})) * PI_W'(err);
		// arithmetic shift is the floor of the Q18.16 product
		acc    = PI_W'(integ_q) + (prod_i >>> FRAC_W);
		lim    = $signed({{(PI_W-LIM_W){1'b0}}, gains.integ_limit, {FRAC_W{1'b0}}});
		if (acc > lim) begin
			acc_c = lim;
		end else if (acc < -lim) begin
			acc_c = -lim;
		end else begin
			acc_c = acc;
		end
		integ_nxt = acc_c[INTEG_W-1:0];
		integ_sh  = $signed({integ_nxt, {FRAC_W{1'b0}}});
		prod_p    = PI_W'($signed({1'b0, gains.gain_prop})) * PI_W'(err);
		prod_d    = PD_W'($signed({1'b0, gains.gain_deriv})) * PD_W'(diff);
		sum       = SUM_W'(prod_p) + SUM_W'(integ_sh) + SUM_W'(prod_d);
		mag       = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
		// truncate toward zero to whole percent, saturate, then dead zone
		if (|mag[SUM_W-1:2*FRAC_W+PCT_W]) begin
			pct = '1;
		end else begin
			pct = mag[2*FRAC_W+PCT_W-1:2*FRAC_W];
		end
		if (pct <= gains.dead_zone) begin
			pct = '0;
		end
		drive_calc = sum[SUM_W-1] ? -$signed({1'b0, pct}) : $signed({1'b0, pct});
	end

	always_comb begin
		if (ctl.clear) begin
			drive_nxt = '0;
		end else if (ctl.tick) begin
			drive_nxt = drive_calc;
		end else begin
			drive_nxt = drive_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q      <= '0;
			integ_q    <= '0;
			last_err_q <= '0;
			drive_q    <= '0;
		end else begin
			drive_q <= drive_nxt;
			if (ctl.clear) begin
				ref_q      <= '0;
				integ_q    <= '0;
				last_err_q <= '0;
			end else if (ctl.tick) begin
				integ_q    <= integ_nxt;
				last_err_q <= err;
			end else if (ctl.set_ref) begin
				ref_q <= ref_val;
			end else if (ctl.zero_ref) begin
				ref_q <= '0;
			end
		end
	end

endmodule
